@@ src/ordered_record_list_assert.svh @@
// Assertion macros for the ordered record list.
// Used at the end of the top level; assumes clk and arst_n are in scope.
`ifndef ORDERED_RECORD_LIST_ASSERT_SVH
`define ORDERED_RECORD_LIST_ASSERT_SVH

// same-cycle implication
`define ORL_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ORL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/orl_pkg.sv @@
// Shared types and constants for the ordered record list.
// No dependencies; imported by orl_ctrl and ordered_record_list.
`default_nettype none

package orl_pkg;

	localparam int ORL_CAPACITY = 64;
	localparam int IDX_W        = $clog2(ORL_CAPACITY);
	localparam int CNT_W        = 7;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_DELETE = 2'd1;
	localparam logic [1:0] FUNC_SEARCH = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic [CNT_W-1:0]   position;
		logic signed [31:0] record_key;
		logic [63:0]        record_payload;
	} cmd_t;

	typedef struct packed {
		logic               ok;
		logic [CNT_W-1:0]   found_position;
		logic signed [31:0] out_key;
		logic [63:0]        out_payload;
		logic [CNT_W-1:0]   list_length;
		logic               list_empty;
	} res_t;

	typedef struct packed {
		logic signed [31:0] key;
		logic [63:0]        payload;
	} rec_t;

endpackage

`default_nettype wire

@@ src/orl_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependency.
`default_nettype none

module orl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ src/orl_ctrl.sv @@
// Command sequencer: validates commands, walks the record RAM one entry per
// cycle for shifts and searches, and registers the result. Uses orl_pkg.
`default_nettype none

module orl_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire orl_pkg::cmd_t        cmd,
	output logic                      done,
	output orl_pkg::res_t             result,
	output logic                      mem_we,
	output logic [orl_pkg::IDX_W-1:0] mem_waddr,
	output orl_pkg::rec_t             mem_wdata,
	output logic [orl_pkg::IDX_W-1:0] mem_raddr,
	input  wire orl_pkg::rec_t        mem_rdata
);

	import orl_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] rd_addr_q;
	logic [IDX_W-1:0] end_q;
	logic             up_q;
	logic             rd_more_q;
	logic             rd_act_s1;
	logic [IDX_W-1:0] rd_addr_s1;
	rec_t             removed_q;
	logic             done_q;
	res_t             result_q;

	logic [CNT_W-1:0] pos_m1;
	logic [CNT_W-1:0] cmd_q_pos_m1;
	logic [CNT_W-1:0] count_m1;
	logic             ins_ok;
	logic             del_ok;
	logic             match;
	logic             drained;
	logic [IDX_W-1:0] first_del;

	assign pos_m1       = cmd.position - CNT_W'(1);
	assign cmd_q_pos_m1 = cmd_q.position - CNT_W'(1);
	assign count_m1     = count_q - CNT_W'(1);
	assign first_del    = cmd_q_pos_m1[IDX_W-1:0];

	assign ins_ok = (count_q < CNT_W'(ORL_CAPACITY)) && (cmd.position != '0)
		&& (pos_m1 <= count_q);
	assign del_ok = (cmd.position != '0) && (cmd.position <= count_q);

	assign match   = rd_act_s1 && (cmd_q.func == FUNC_SEARCH)
		&& (mem_rdata.key == cmd_q.record_key);
	assign drained = !rd_more_q && !rd_act_s1;

	assign mem_raddr = rd_addr_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_addr_s1;
		mem_wdata = mem_rdata;
		if (state_q == ST_RUN) begin
			if (rd_act_s1 && cmd_q.func == FUNC_INSERT) begin
				mem_we    = 1'b1;
				mem_waddr = rd_addr_s1 + IDX_W'(1);
			end else if (rd_act_s1 && cmd_q.func == FUNC_DELETE && rd_addr_s1 != first_del) begin
				mem_we    = 1'b1;
				mem_waddr = rd_addr_s1 - IDX_W'(1);
			end else if (drained && cmd_q.func == FUNC_INSERT) begin
				mem_we            = 1'b1;
				mem_waddr         = cmd_q_pos_m1[IDX_W-1:0];
				mem_wdata.key     = cmd_q.record_key;
				mem_wdata.payload = cmd_q.record_payload;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rd_more_q  <= 1'b0;
			rd_act_s1  <= 1'b0;
			done_q     <= 1'b0;
			up_q       <= 1'b0;
			rd_addr_q  <= '0;
			end_q      <= '0;
			rd_addr_s1 <= '0;
			cmd_q      <= '0;
			removed_q  <= '0;
			result_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					rd_act_s1 <= 1'b0;
					if (start) begin
						cmd_q <= cmd;
						case (cmd.func)
							FUNC_INSERT: begin
								rd_addr_q <= count_m1[IDX_W-1:0];
								end_q     <= pos_m1[IDX_W-1:0];
								up_q      <= 1'b0;
								rd_more_q <= (pos_m1 != count_q);
							end
							FUNC_DELETE: begin
								rd_addr_q <= pos_m1[IDX_W-1:0];
								end_q     <= count_m1[IDX_W-1:0];
								up_q      <= 1'b1;
								rd_more_q <= 1'b1;
							end
							default: begin
								rd_addr_q <= '0;
								end_q     <= count_m1[IDX_W-1:0];
								up_q      <= 1'b1;
								rd_more_q <= (count_q != '0);
							end
						endcase
						if ((cmd.func == FUNC_INSERT && ins_ok)
							|| (cmd.func == FUNC_DELETE && del_ok)
							|| (cmd.func == FUNC_SEARCH)) begin
							state_q <= ST_RUN;
						end else begin
							done_q               <= 1'b1;
							result_q             <= '0;
							result_q.list_length <= count_q;
							result_q.list_empty  <= (count_q == '0);
						end
					end
				end
				ST_RUN: begin
					if (rd_more_q) begin
						rd_act_s1  <= 1'b1;
						rd_addr_s1 <= rd_addr_q;
						if (rd_addr_q == end_q) begin
							rd_more_q <= 1'b0;
						end else if (up_q) begin
							rd_addr_q <= rd_addr_q + IDX_W'(1);
						end else begin
							rd_addr_q <= rd_addr_q - IDX_W'(1);
						end
					end else begin
						rd_act_s1 <= 1'b0;
					end
					if (rd_act_s1 && cmd_q.func == FUNC_DELETE && rd_addr_s1 == first_del) begin
						removed_q <= mem_rdata;
					end
					if (match) begin
						state_q                 <= ST_IDLE;
						rd_more_q               <= 1'b0;
						rd_act_s1               <= 1'b0;
						done_q                  <= 1'b1;
						result_q.ok             <= 1'b1;
						result_q.found_position <= CNT_W'(rd_addr_s1) + CNT_W'(1);
						result_q.out_key        <= mem_rdata.key;
						result_q.out_payload    <= mem_rdata.payload;
						result_q.list_length    <= count_q;
						result_q.list_empty     <= (count_q == '0);
					end else if (drained) begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						result_q <= '0;
						case (cmd_q.func)
							FUNC_INSERT: begin
								count_q              <= count_q + CNT_W'(1);
								result_q.ok          <= 1'b1;
								result_q.list_length <= count_q + CNT_W'(1);
								result_q.list_empty  <= 1'b0;
							end
							FUNC_DELETE: begin
								count_q              <= count_m1;
								result_q.ok          <= 1'b1;
								result_q.out_key     <= removed_q.key;
								result_q.out_payload <= removed_q.payload;
								result_q.list_length <= count_m1;
								result_q.list_empty  <= (count_m1 == '0);
							end
							default: begin
								result_q.list_length <= count_q;
								result_q.list_empty  <= (count_q == '0);
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q == ST_RUN);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

@@ src/ordered_record_list.sv @@
// Top level of the ordered record list: sequencer plus record RAM.
// Depends on orl_pkg, orl_ram, orl_ctrl and ordered_record_list_assert.svh.
//
//   channel  | handshake         | payload
//   ---------+-------------------+------------------------
//   command  | start, busy       | cmd    (orl_pkg::cmd_t)
//   result   | done (1 cycle)    | result (orl_pkg::res_t)
//
// A rejected command answers in the cycle after it is taken; insert and
// delete answer once their shift is done, search on a match or at the end
// of its scan: shifts and scans move one entry per cycle through the
// single-read, single-write RAM.
// Reset clears the length only; the RAM is not cleared and holds no data
// that a command can reach until written. Results cannot be stalled.
`default_nettype none

module ordered_record_list (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire orl_pkg::cmd_t cmd,
	output logic               done,
	output orl_pkg::res_t      result
);

	import orl_pkg::*;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	rec_t             mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	rec_t             mem_rdata;

	orl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	orl_ram #(
		.WIDTH ($bits(rec_t)),
		.DEPTH (ORL_CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

`include "ordered_record_list_assert.svh"

	`ORL_ASSERT_NEXT(a_take_progress, start && !busy, busy || done, "accepted item neither running nor answered")
	`ORL_ASSERT_IMPLY(a_empty_flag, done, result.list_empty == (result.list_length == '0), "empty flag disagrees with length")
	`ORL_ASSERT_IMPLY(a_len_cap, done, result.list_length <= CNT_W'(ORL_CAPACITY), "length beyond capacity")
	`ORL_ASSERT_IMPLY(a_fail_clear, done && !result.ok, result.found_position == '0 && result.out_key == '0 && result.out_payload == '0, "failed result carries data")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for ordered_record_list: directed and random insert, delete and
// search commands, each result checked against a tracked copy of the list contents.
// Depends on orl_pkg and the ordered_record_list top level.

module tb_top;
	import orl_pkg::*;

	localparam logic [1:0] FUNC_UNUSED  = 2'd3;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 100;
	localparam int MAX_PRINTED    = 40;

	class record_list_tracker;
		logic signed [31:0] keys [ORL_CAPACITY];
		logic [63:0]        payloads [ORL_CAPACITY];
		int                 used = 0;
		res_t               expected [$];
		int                 errors = 0;
		int                 results_seen = 0;
		int                 peak = 0;
		int                 full_refusals = 0;
		int                 search_hits = 0;
		int                 per_func [4] = '{default: 0};

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		function res_t execute(cmd_t c);
			res_t r;
			int   pos;
			r = '0;
			pos = c.position;
			case (c.func)
			FUNC_INSERT: begin
				if (used >= ORL_CAPACITY)
					full_refusals++;
				if (used < ORL_CAPACITY && pos >= 1 && pos <= used + 1) begin
					for (int k = used; k >= pos; k--) begin
						keys[k]     = keys[k - 1];
						payloads[k] = payloads[k - 1];
					end
					keys[pos - 1]     = c.record_key;
					payloads[pos - 1] = c.record_payload;
					used++;
					r.ok = 1'b1;
				end
			end
			FUNC_DELETE: begin
				if (pos >= 1 && pos <= used) begin
					r.ok          = 1'b1;
					r.out_key     = keys[pos - 1];
					r.out_payload = payloads[pos - 1];
					for (int k = pos; k < used; k++) begin
						keys[k - 1]     = keys[k];
						payloads[k - 1] = payloads[k];
					end
					used--;
				end
			end
			FUNC_SEARCH: begin
				for (int k = 0; k < used && !r.ok; k++) begin
					if (keys[k] == c.record_key) begin
						r.ok             = 1'b1;
						r.found_position = CNT_W'(k + 1);
						r.out_key        = keys[k];
						r.out_payload    = payloads[k];
					end
				end
				if (r.ok)
					search_hits++;
			end
			default: begin
			end
			endcase
			r.list_length = CNT_W'(used);
			r.list_empty  = (used == 0);
			return r;
		endfunction

		function void take_command(cmd_t c);
			per_func[c.func]++;
			expected.push_back(execute(c));
			if (used > peak)
				peak = used;
		endfunction

		task compare_field(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("result %0d field %s: got %h, expected %h",
					results_seen, name, got, want));
		endtask

		task check_result(res_t got);
			res_t want;
			if (expected.size() == 0) begin
				report($sformatf("result with no command outstanding: %h", got));
				return;
			end
			want = expected.pop_front();
			results_seen++;
			compare_field("ok", 64'(got.ok), 64'(want.ok));
			compare_field("found_position", 64'(got.found_position),
				64'(want.found_position));
			compare_field("out_key", 64'(got.out_key), 64'(want.out_key));
			compare_field("out_payload", got.out_payload, want.out_payload);
			compare_field("list_length", 64'(got.list_length), 64'(want.list_length));
			compare_field("list_empty", 64'(got.list_empty), 64'(want.list_empty));
		endtask
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	cmd_t  cmd = '0;
	logic  busy;
	logic  done;
	res_t  result;
	int    quiet = 0;

	record_list_tracker tracker = new();

	ordered_record_list dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet <= 0;
		end else begin
			if (done)
				tracker.check_result(result);
			if (done || (start && !busy))
				quiet <= 0;
			else
				quiet <= quiet + 1;
		end
	end

	function automatic cmd_t make_cmd(logic [1:0] f, int p, logic signed [31:0] k,
		logic [63:0] d);
		cmd_t c;
		c.func           = f;
		c.position       = p[CNT_W-1:0];
		c.record_key     = k;
		c.record_payload = d;
		return c;
	endfunction

	function automatic logic signed [31:0] pick_key();
		case ($urandom_range(0, 9))
		0: begin
			return 32'sh8000_0000;
		end
		1: begin
			return 32'sh7fff_ffff;
		end
		2: begin
			return 32'sd0;
		end
		3: begin
			return -32'sd1;
		end
		4, 5: begin
			return $urandom_range(1, 8);
		end
		default: begin
			return $urandom;
		end
		endcase
	endfunction

	// mode 0 grows the list, 1 mixes, 2 drains it
	function automatic cmd_t random_command(int mode);
		int          ins_cut [3] = '{60, 35, 12};
		int          del_cut [3] = '{75, 65, 70};
		int          roll;
		int          pos;
		logic [1:0]  f;
		logic signed [31:0] k;
		roll = $urandom_range(0, 99);
		if (roll < ins_cut[mode])
			f = FUNC_INSERT;
		else if (roll < del_cut[mode])
			f = FUNC_DELETE;
		else if (roll < 97)
			f = FUNC_SEARCH;
		else
			f = FUNC_UNUSED;
		if ($urandom_range(0, 99) < 15)
			pos = $urandom_range(0, 65);
		else if (f == FUNC_DELETE)
			pos = (tracker.used > 0) ? $urandom_range(1, tracker.used) : 1;
		else if (tracker.used < ORL_CAPACITY)
			pos = $urandom_range(1, tracker.used + 1);
		else
			pos = $urandom_range(1, 65);
		if (f == FUNC_SEARCH && tracker.used > 0 && $urandom_range(0, 1))
			k = tracker.keys[$urandom_range(0, tracker.used - 1)];
		else
			k = pick_key();
		return make_cmd(f, pos, k, {$urandom, $urandom});
	endfunction

	task automatic send(input cmd_t c);
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		tracker.take_command(c);
	endtask

	task automatic pause(input bit allowed);
		if (allowed && $urandom_range(0, 99) < 15) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 80)) @(posedge clk);
		end
	endtask

	initial begin
		while (quiet < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		cmd_t directed [$];
		directed.push_back(make_cmd(FUNC_SEARCH, 0, 0, '0));
		directed.push_back(make_cmd(FUNC_DELETE, 1, 0, '0));
		directed.push_back(make_cmd(FUNC_DELETE, 0, 0, '0));
		directed.push_back(make_cmd(FUNC_INSERT, 0, 5, 64'h1));
		directed.push_back(make_cmd(FUNC_INSERT, 2, 5, 64'h1));
		directed.push_back(make_cmd(FUNC_INSERT, 1, 32'sh8000_0000, '1));
		directed.push_back(make_cmd(FUNC_INSERT, 2, 32'sh7fff_ffff, '0));
		directed.push_back(make_cmd(FUNC_INSERT, 1, -32'sd1, 64'h5555_5555_5555_5555));
		directed.push_back(make_cmd(FUNC_INSERT, 4, 0, 64'haaaa_aaaa_aaaa_aaaa));
		directed.push_back(make_cmd(FUNC_INSERT, 6, 9, 64'h9));
		directed.push_back(make_cmd(FUNC_SEARCH, 0, 32'sh7fff_ffff, '0));
		directed.push_back(make_cmd(FUNC_SEARCH, 3, 12345, '1));
		directed.push_back(make_cmd(FUNC_INSERT, 2, 32'sh7fff_ffff, 64'h1));
		directed.push_back(make_cmd(FUNC_SEARCH, 0, 32'sh7fff_ffff, 64'h77));
		directed.push_back(make_cmd(FUNC_UNUSED, 1, -32'sd1, '1));
		directed.push_back(make_cmd(FUNC_DELETE, 6, 0, '0));
		directed.push_back(make_cmd(FUNC_DELETE, 5, 0, '0));
		directed.push_back(make_cmd(FUNC_DELETE, 1, 0, '0));
		directed.push_back(make_cmd(FUNC_INSERT, 65, 7, 64'h7));
		directed.push_back(make_cmd(FUNC_DELETE, 64, 0, '0));
		directed.push_back(make_cmd(FUNC_SEARCH, 0, 32'sh8000_0000, '0));
		directed.push_back(make_cmd(FUNC_DELETE, 2, 0, '0));
		directed.push_back(make_cmd(FUNC_SEARCH, 0, 0, '0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			send(directed[i]);
			pause(1'b1);
		end
		// hold the command stream solid for random items 600 to 899
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			send(random_command((i / 150) % 3));
			pause(i < 600 || i >= 900);
		end
		start <= 1'b0;

		while (tracker.expected.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d commands: %0d insert, %0d delete, %0d search, %0d unused code",
			tracker.per_func[FUNC_INSERT] + tracker.per_func[FUNC_DELETE] +
			tracker.per_func[FUNC_SEARCH] + tracker.per_func[FUNC_UNUSED],
			tracker.per_func[FUNC_INSERT], tracker.per_func[FUNC_DELETE],
			tracker.per_func[FUNC_SEARCH], tracker.per_func[FUNC_UNUSED]);
		$display("%0d results checked, %0d search hits, peak length %0d, %0d inserts on a full list",
			tracker.results_seen, tracker.search_hits, tracker.peak, tracker.full_refusals);
		if (tracker.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
